[rtl/core/sri_pkg.sv]
// Shared types and constants for the stimulation re-enable interlock.
// Holds the phase, event, mode and register-index codes and the payload structs.
// No dependencies; sri_cfg, sri_engine and the top level import this package.
`timescale 1ns / 1ps

package sri_pkg;

  // Interlock phases; codes five to seven are never entered.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LOCKOUT   = 3'd1,
    PH_AWAIT     = 3'd2,
    PH_IMPEDANCE = 3'd3,
    PH_ASSERTING = 3'd4
  } phase_t;

  // Event codes reported with each result.
  typedef enum logic [3:0] {
    EV_NONE           = 4'd0,
    EV_CUTOFF         = 4'd1,
    EV_CLEARED        = 4'd2,
    EV_CONFIRM_OPEN   = 4'd3,
    EV_IMP_FAIL       = 4'd4,
    EV_IMP_PASS       = 4'd5,
    EV_IMP_TIMEOUT    = 4'd6,
    EV_COMPLETE       = 4'd7,
    EV_ASSERT_TIMEOUT = 4'd8
  } event_t;

  // Item kinds; the fourth code carries no meaning and is ignored.
  typedef enum logic [1:0] {
    MODE_HEARTBEAT = 2'd0,
    MODE_CONFIRM   = 2'd1,
    MODE_RESET     = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOCKOUT_TIME   = 2'd0,
    REG_IMPEDANCE_TIME = 2'd1,
    REG_ASSERT_TIME    = 2'd2,
    REG_CARDIAC_MASK   = 2'd3
  } reg_index_t;

  localparam logic [31:0] LOCKOUT_TIME_RESET   = 32'd30000;
  localparam logic [31:0] IMPEDANCE_TIME_RESET = 32'd5000;
  localparam logic [31:0] ASSERT_TIME_RESET    = 32'd2000;
  localparam logic [7:0]  CARDIAC_MASK_RESET   = 8'd1;

  // Configuration register contents.
  typedef struct packed {
    logic [31:0] lockout_time;
    logic [31:0] impedance_time_limit;
    logic [31:0] assert_time_limit;
    logic [7:0]  cardiac_bit_mask;
  } cfg_regs_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  status_byte;
    logic        session_active;
    logic [31:0] now_time;
    logic        start_accepted;
    logic        impedance_done;
    logic        impedance_passed;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [3:0] event_code;
    logic       confirm_accepted;
    logic       start_request;
    logic       reenable_active;
    logic [2:0] phase_code;
  } result_t;

endpackage

[rtl/core/sri_ifs.sv]
// Handshake channel interfaces for the re-enable interlock: items, results, config.
// Each carries valid, ready and payload, with source and sink modports.
// No dependencies.
`timescale 1ns / 1ps

interface sri_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  status_byte;
  logic        session_active;
  logic [31:0] now_time;
  logic        start_accepted;
  logic        impedance_done;
  logic        impedance_passed;

  modport source (output valid, mode, status_byte, session_active, now_time,
                  start_accepted, impedance_done, impedance_passed, input ready);
  modport sink (input valid, mode, status_byte, session_active, now_time,
                start_accepted, impedance_done, impedance_passed, output ready);
endinterface

interface sri_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic       confirm_accepted;
  logic       start_request;
  logic       reenable_active;
  logic [2:0] phase_code;

  modport source (output valid, event_code, confirm_accepted, start_request,
                  reenable_active, phase_code, input ready);
  modport sink (input valid, event_code, confirm_accepted, start_request,
                reenable_active, phase_code, output ready);
endinterface

interface sri_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/sri_cfg.sv]
// Configuration register bank of the re-enable interlock.
// Depends on sri_pkg and the sri_cfg_if interface.
`timescale 1ns / 1ps

module sri_cfg
  import sri_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sri_cfg_if.sink   cfg,
  output cfg_regs_t regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register write on each configuration transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lockout_time         <= LOCKOUT_TIME_RESET;
      regs.impedance_time_limit <= IMPEDANCE_TIME_RESET;
      regs.assert_time_limit    <= ASSERT_TIME_RESET;
      regs.cardiac_bit_mask     <= CARDIAC_MASK_RESET;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_LOCKOUT_TIME:   regs.lockout_time         <= cfg.data;
        REG_IMPEDANCE_TIME: regs.impedance_time_limit <= cfg.data;
        REG_ASSERT_TIME:    regs.assert_time_limit    <= cfg.data;
        REG_CARDIAC_MASK:   regs.cardiac_bit_mask     <= cfg.data[7:0];
        default:            regs                      <= regs;
      endcase
    end
  end

endmodule

[rtl/core/sri_engine.sv]
// Phase machine of the re-enable interlock: state registers, next-state and result logic.
// Depends on sri_pkg. Consumes one registered item per step and returns its result.
`timescale 1ns / 1ps

module sri_engine
  import sri_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  item_t     item,
  input  cfg_regs_t regs,
  output result_t   res
);

  phase_t      phase, phase_next;
  logic        prev_cardiac, prev_cardiac_next;
  logic [31:0] cutoff_time, cutoff_time_next;
  logic [31:0] check_time, check_time_next;
  logic [31:0] assert_time, assert_time_next;
  logic        confirm_pending, confirm_pending_next;

  mode_t       mode;
  logic        heartbeat, cardiac, rising, phase_legal, clear_req;
  logic [31:0] lock_elapsed, check_elapsed, assert_elapsed;
  logic        lock_done, check_expired, assert_expired;
  event_t      event_code;

  // Item decode and the three wrap-safe elapsed-time compares.
  always_comb begin
    mode           = mode_t'(item.mode);
    heartbeat      = (mode == MODE_HEARTBEAT);
    cardiac        = |(item.status_byte & regs.cardiac_bit_mask);
    rising         = cardiac && !prev_cardiac;
    phase_legal    = (phase <= PH_ASSERTING);
    lock_elapsed   = item.now_time - cutoff_time;
    check_elapsed  = item.now_time - check_time;
    assert_elapsed = item.now_time - assert_time;
    lock_done      = (lock_elapsed >= regs.lockout_time);
    check_expired  = (check_elapsed >= regs.impedance_time_limit);
    assert_expired = (assert_elapsed >= regs.assert_time_limit);
    // Session reset, stopped session, cleared cardiac bit or a bad phase wipe the state.
    clear_req = (mode == MODE_RESET) ||
                (heartbeat && (!item.session_active ||
                 (!rising && (phase != PH_IDLE) && (!phase_legal || !cardiac))));
  end

  // Next-state logic.
  always_comb begin
    phase_next           = phase;
    prev_cardiac_next    = prev_cardiac;
    cutoff_time_next     = cutoff_time;
    check_time_next      = check_time;
    assert_time_next     = assert_time;
    confirm_pending_next = confirm_pending;
    if (clear_req) begin
      phase_next           = PH_IDLE;
      prev_cardiac_next    = 1'b0;
      cutoff_time_next     = '0;
      check_time_next      = '0;
      assert_time_next     = '0;
      confirm_pending_next = 1'b0;
    end else if (heartbeat) begin
      prev_cardiac_next = cardiac;
      if (rising) begin
        phase_next           = PH_LOCKOUT;
        cutoff_time_next     = item.now_time;
        confirm_pending_next = 1'b0;
      end else begin
        unique case (phase)
          PH_LOCKOUT: begin
            if (lock_done) phase_next = PH_AWAIT;
          end
          PH_AWAIT: begin
            if (confirm_pending) begin
              confirm_pending_next = 1'b0;
              if (item.start_accepted) begin
                check_time_next = item.now_time;
                phase_next      = PH_IMPEDANCE;
              end
            end
          end
          PH_IMPEDANCE: begin
            if (item.impedance_done) begin
              if (item.impedance_passed) begin
                phase_next       = PH_ASSERTING;
                assert_time_next = item.now_time;
              end else begin
                phase_next = PH_AWAIT;
              end
            end else if (check_expired) begin
              phase_next = PH_AWAIT;
            end
          end
          PH_ASSERTING: begin
            if (assert_expired) phase_next = PH_AWAIT;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end else if (mode == MODE_CONFIRM && phase == PH_AWAIT) begin
      confirm_pending_next = 1'b1;
    end
  end

  // Result logic.
  always_comb begin
    event_code = EV_NONE;
    if (heartbeat && item.session_active) begin
      if (rising) begin
        event_code = EV_CUTOFF;
      end else if (phase != PH_IDLE && phase_legal) begin
        if (!cardiac) begin
          event_code = (phase == PH_ASSERTING) ? EV_COMPLETE : EV_CLEARED;
        end else begin
          unique case (phase)
            PH_LOCKOUT: begin
              if (lock_done) event_code = EV_CONFIRM_OPEN;
            end
            PH_AWAIT: begin
              if (confirm_pending && !item.start_accepted) event_code = EV_IMP_FAIL;
            end
            PH_IMPEDANCE: begin
              if (item.impedance_done) begin
                event_code = item.impedance_passed ? EV_IMP_PASS : EV_IMP_FAIL;
              end else if (check_expired) begin
                event_code = EV_IMP_TIMEOUT;
              end
            end
            PH_ASSERTING: begin
              if (assert_expired) event_code = EV_ASSERT_TIMEOUT;
            end
            default: begin
              event_code = EV_NONE;
            end
          endcase
        end
      end
    end
    res.event_code       = event_code;
    res.confirm_accepted = (mode == MODE_CONFIRM) && (phase == PH_AWAIT);
    res.start_request    = heartbeat && item.session_active && !rising && cardiac &&
                           (phase == PH_AWAIT) && confirm_pending;
    res.reenable_active  = (phase_next == PH_ASSERTING);
    res.phase_code       = phase_next;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      prev_cardiac    <= 1'b0;
      cutoff_time     <= '0;
      check_time      <= '0;
      assert_time     <= '0;
      confirm_pending <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      prev_cardiac    <= prev_cardiac_next;
      cutoff_time     <= cutoff_time_next;
      check_time      <= check_time_next;
      assert_time     <= assert_time_next;
      confirm_pending <= confirm_pending_next;
    end
  end

  // A posted confirm only lives in the await-confirm phase.
  a_pending_in_await: assert property (@(posedge clk) disable iff (rst)
    confirm_pending |-> phase == PH_AWAIT)
    else $error("confirm pending outside await-confirm phase");

  // An impedance start is only requested from await-confirm with a posted confirm.
  a_start_from_await: assert property (@(posedge clk) disable iff (rst)
    step && res.start_request |-> phase == PH_AWAIT && confirm_pending)
    else $error("start request without pending confirm");

  // A confirm item never moves the phase.
  a_confirm_holds_phase: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_CONFIRM |=> $stable(phase))
    else $error("confirm item changed the phase");

  // Asserting is only reached through a passed impedance check.
  a_assert_entry: assert property (@(posedge clk) disable iff (rst)
    step && phase_next == PH_ASSERTING |->
      (phase == PH_IMPEDANCE || phase == PH_ASSERTING))
    else $error("asserting phase entered without impedance pass");

endmodule

[rtl/core/stimulation_reenable_interlock_top.sv]
// Stimulation re-enable interlock, top level: input register, phase engine, result register.
// An item is held in the input register, and its result then waits in the result register until taken.
// Throughput: one item per cycle while result.ready holds; the input and result registers let both sides stall freely.
// Reset (rst, synchronous, active high) sets phase idle, clears all timers and flags,
// empties both registers and loads the configuration defaults.
// Depends on sri_pkg, sri_ifs, sri_cfg and sri_engine.
`timescale 1ns / 1ps

module stimulation_reenable_interlock_top
  import sri_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sri_item_if.sink       item,
  sri_result_if.source   result,
  sri_cfg_if.sink        cfg
);

  cfg_regs_t regs;
  logic      hold_valid;
  item_t     hold_item;
  logic      out_valid;
  result_t   out_result;
  result_t   step_result;
  logic      advance;

  sri_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Held item moves on whenever the result register is free or being drained.
  assign advance    = hold_valid && (!out_valid || result.ready);
  assign item.ready = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_item.mode             <= item.mode;
      hold_item.status_byte      <= item.status_byte;
      hold_item.session_active   <= item.session_active;
      hold_item.now_time         <= item.now_time;
      hold_item.start_accepted   <= item.start_accepted;
      hold_item.impedance_done   <= item.impedance_done;
      hold_item.impedance_passed <= item.impedance_passed;
    end
  end

  sri_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (hold_item),
    .regs (regs),
    .res  (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign result.valid            = out_valid;
  assign result.event_code       = out_result.event_code;
  assign result.confirm_accepted = out_result.confirm_accepted;
  assign result.start_request    = out_result.start_request;
  assign result.reenable_active  = out_result.reenable_active;
  assign result.phase_code       = out_result.phase_code;

endmodule
